// ----- src/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, codes and helpers for the stuffed frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] BYTE_MASK   = 8'hFF;

   // position of the next byte within a frame
   localparam logic [2:0] POS_IDLE    = 3'd0;
   localparam logic [2:0] POS_OPCODE  = 3'd1;
   localparam logic [2:0] POS_TYPE    = 3'd2;
   localparam logic [2:0] POS_LENGTH  = 3'd3;
   localparam logic [2:0] POS_PAYLOAD = 3'd4;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } sfd_kind_type;

   typedef enum logic [1:0] {
      STATUS_GOOD   = 2'd0,
      STATUS_BADSUM = 2'd1,
      STATUS_SHORT  = 2'd2
   } sfd_status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
      logic       frame_end;
   } sfd_req_type;

   typedef struct packed {
      sfd_kind_type   kind;
      logic [7:0]     data_byte;
      logic [7:0]     opcode_field;
      logic [7:0]     type_field;
      logic [7:0]     declared_length;
      sfd_status_type status;
      logic           last;
   } sfd_rsp_type;

   // one queued input transaction: one or two results
   typedef struct packed {
      logic        pair;
      sfd_rsp_type first;
      sfd_rsp_type second;
   } sfd_entry_type;

   function automatic sfd_rsp_type make_rsp(
      input sfd_kind_type   kind,
      input logic [7:0]     data,
      input logic [7:0]     opcode,
      input logic [7:0]     dtype,
      input logic [7:0]     length,
      input sfd_status_type status
   );
      sfd_rsp_type r;
      r.kind            = kind;
      r.data_byte       = data;
      r.opcode_field    = opcode;
      r.type_field      = dtype;
      r.declared_length = length;
      r.status          = status;
      r.last            = 1'b0;
      return r;
   endfunction

endpackage

// ----- src/sfd_front.sv -----
// ----------------------------------------------------------------------------
// sfd_front
// Frame tracking, header capture, checksum and unstuffing; builds entries.
// ----------------------------------------------------------------------------
module sfd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  sfd_pkg::sfd_req_type  req,
   output logic                  push,
   output sfd_pkg::sfd_entry_type entry
);

   logic       in_frame_ff, in_frame_in;
   logic [2:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] opcode_ff, opcode_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] length_ff, length_in;
   logic       slash_ff, slash_in;

   logic                 have_first;
   logic                 have_second;
   sfd_pkg::sfd_rsp_type first_rsp;
   sfd_pkg::sfd_rsp_type second_rsp;
   sfd_pkg::sfd_status_type end_status;

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      opcode_in   = opcode_ff;
      type_in     = type_ff;
      length_in   = length_ff;
      slash_in    = slash_ff;
      have_first  = 1'b0;
      have_second = 1'b0;
      first_rsp   = '0;
      second_rsp  = '0;
      end_status  = sfd_pkg::STATUS_GOOD;

      if (req.frame_start) begin
         // a start inside an open frame closes it as too short
         if (in_frame_ff) begin
            have_first = 1'b1;
            first_rsp  = sfd_pkg::make_rsp(sfd_pkg::KIND_STATUS, 8'd0, opcode_ff, type_ff,
                                           length_ff, sfd_pkg::STATUS_SHORT);
         end
         in_frame_in = 1'b1;
         pos_in      = sfd_pkg::POS_OPCODE;
         sum_in      = 8'd0;
         opcode_in   = 8'd0;
         type_in     = 8'd0;
         length_in   = 8'd0;
         slash_in    = 1'b0;
         if (req.frame_end) begin
            if (in_frame_ff) begin
               have_second = 1'b1;
               second_rsp  = sfd_pkg::make_rsp(sfd_pkg::KIND_STATUS, 8'd0, 8'd0, 8'd0, 8'd0,
                                               sfd_pkg::STATUS_SHORT);
            end else begin
               have_first = 1'b1;
               first_rsp  = sfd_pkg::make_rsp(sfd_pkg::KIND_STATUS, 8'd0, 8'd0, 8'd0, 8'd0,
                                              sfd_pkg::STATUS_SHORT);
            end
            in_frame_in = 1'b0;
            pos_in      = sfd_pkg::POS_IDLE;
         end
      end else if (in_frame_ff) begin
         if (req.frame_end) begin
            if (pos_ff != sfd_pkg::POS_PAYLOAD) begin
               end_status = sfd_pkg::STATUS_SHORT;
            end else if (req.rx_byte == (sum_ff ^ sfd_pkg::BYTE_MASK)) begin
               end_status = sfd_pkg::STATUS_GOOD;
            end else begin
               end_status = sfd_pkg::STATUS_BADSUM;
            end
            if (slash_ff) begin
               have_first  = 1'b1;
               have_second = 1'b1;
               first_rsp   = sfd_pkg::make_rsp(sfd_pkg::KIND_DATA, sfd_pkg::CHAR_SLASH,
                                               opcode_ff, type_ff, length_ff,
                                               sfd_pkg::STATUS_GOOD);
               second_rsp  = sfd_pkg::make_rsp(sfd_pkg::KIND_STATUS, 8'd0, opcode_ff,
                                               type_ff, length_ff, end_status);
            end else begin
               have_first = 1'b1;
               first_rsp  = sfd_pkg::make_rsp(sfd_pkg::KIND_STATUS, 8'd0, opcode_ff,
                                              type_ff, length_ff, end_status);
            end
            in_frame_in = 1'b0;
            pos_in      = sfd_pkg::POS_IDLE;
            slash_in    = 1'b0;
         end else begin
            sum_in = sum_ff + req.rx_byte;
            unique case (pos_ff)
               sfd_pkg::POS_OPCODE: begin
                  opcode_in = req.rx_byte;
                  pos_in    = sfd_pkg::POS_TYPE;
               end
               sfd_pkg::POS_TYPE: begin
                  type_in = req.rx_byte;
                  pos_in  = sfd_pkg::POS_LENGTH;
               end
               sfd_pkg::POS_LENGTH: begin
                  length_in = req.rx_byte;
                  pos_in    = sfd_pkg::POS_PAYLOAD;
               end
               default: begin
                  pos_in = sfd_pkg::POS_PAYLOAD;
                  if (slash_ff) begin
                     slash_in   = 1'b0;
                     have_first = 1'b1;
                     if (req.rx_byte == sfd_pkg::CHAR_DOLLAR) begin
                        first_rsp = sfd_pkg::make_rsp(sfd_pkg::KIND_DATA, sfd_pkg::CHAR_DOLLAR,
                                                      opcode_ff, type_ff, length_ff,
                                                      sfd_pkg::STATUS_GOOD);
                     end else begin
                        first_rsp = sfd_pkg::make_rsp(sfd_pkg::KIND_DATA, sfd_pkg::CHAR_SLASH,
                                                      opcode_ff, type_ff, length_ff,
                                                      sfd_pkg::STATUS_GOOD);
                        if (req.rx_byte == sfd_pkg::CHAR_SLASH) begin
                           slash_in = 1'b1;
                        end else begin
                           have_second = 1'b1;
                           second_rsp  = sfd_pkg::make_rsp(sfd_pkg::KIND_DATA, req.rx_byte,
                                                           opcode_ff, type_ff, length_ff,
                                                           sfd_pkg::STATUS_GOOD);
                        end
                     end
                  end else if (req.rx_byte == sfd_pkg::CHAR_SLASH) begin
                     slash_in = 1'b1;
                  end else begin
                     have_first = 1'b1;
                     first_rsp  = sfd_pkg::make_rsp(sfd_pkg::KIND_DATA, req.rx_byte,
                                                    opcode_ff, type_ff, length_ff,
                                                    sfd_pkg::STATUS_GOOD);
                  end
               end
            endcase
         end
      end

      if (have_second) begin
         second_rsp.last = 1'b1;
      end else begin
         first_rsp.last = 1'b1;
      end
   end

   assign push         = accept && have_first;
   assign entry.pair   = have_second;
   assign entry.first  = first_rsp;
   assign entry.second = second_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= sfd_pkg::POS_IDLE;
         sum_ff      <= 8'd0;
         opcode_ff   <= 8'd0;
         type_ff     <= 8'd0;
         length_ff   <= 8'd0;
         slash_ff    <= 1'b0;
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         opcode_ff   <= opcode_in;
         type_ff     <= type_in;
         length_ff   <= length_in;
         slash_ff    <= slash_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pos_tracks_frame: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == sfd_pkg::POS_IDLE) == !in_frame_ff)
      else $error("byte position out of step with frame state");

   a_slash_in_payload: assert property (@(posedge clock) disable iff (reset)
      slash_ff |-> (in_frame_ff && pos_ff == sfd_pkg::POS_PAYLOAD))
      else $error("pending slash outside payload");
`endif

endmodule

// ----- src/sfd_queue.sv -----
// ----------------------------------------------------------------------------
// sfd_queue
// Small register queue of entries between front and back.
// ----------------------------------------------------------------------------
module sfd_queue #(
   parameter int unsigned DEPTH = sfd_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sfd_pkg::sfd_entry_type push_entry,
   input  logic                   pop,
   output sfd_pkg::sfd_entry_type head,
   output logic                   empty,
   output logic                   full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   sfd_pkg::sfd_entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
   endfunction

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");
`endif

endmodule

// ----- src/sfd_back.sv -----
// ----------------------------------------------------------------------------
// sfd_back
// Unpacks queued entries into single results behind an output register.
// ----------------------------------------------------------------------------
module sfd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sfd_pkg::sfd_entry_type head,
   input  logic                   head_valid,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sfd_pkg::sfd_rsp_type   rsp_payload
);

   logic                 rsp_valid_ff, rsp_valid_in;
   sfd_pkg::sfd_rsp_type rsp_data_ff;
   logic                 idx_ff, idx_in;
   logic                 load;

   // output register free, or emptied this cycle
   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && (!head.pair || idx_ff);

   always_comb begin
      idx_in       = load ? (head.pair && !idx_ff) : idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= idx_ff ? head.second : head.first;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_second_needs_pair: assert property (@(posedge clock) disable iff (reset)
      idx_ff |-> (head_valid && head.pair))
      else $error("second result selected without a paired entry");
`endif

endmodule

// ----- src/stuffed_frame_deframer_core.sv -----
// Path: a result reaches rsp through the entry queue, which the front writes on the edge that
// accepts its byte transaction, and then the output register, which the back loads from it.
// Throughput: one byte per cycle while req_stall is low; a byte that yields two results
// holds the output port for both results in turn, and the entry queue absorbs these bursts.
// req_stall rises only when the entry queue (QUEUE_DEPTH entries) is full.
// Reset is synchronous and active high; it clears frame state, queue and output valid.
// ----------------------------------------------------------------------------
// stuffed_frame_deframer_core
// Byte-stuffed frame deframer with header capture and inverted-sum check.
// ----------------------------------------------------------------------------
module stuffed_frame_deframer_core #(
   parameter int unsigned QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   // byte transactions in
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sfd_pkg::sfd_req_type req_payload,
   // result transactions out
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sfd_pkg::sfd_rsp_type rsp_payload
);

   logic                   accept;
   logic                   push;
   logic                   pop;
   logic                   q_empty;
   logic                   q_full;
   sfd_pkg::sfd_entry_type push_entry;
   sfd_pkg::sfd_entry_type head;

   // Stall from the full flag of the registered queue count, so no path from rsp_stall to req_stall.
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // Front: tracks the frame, sums, captures header, undoes '/' '$' stuffing.
   // Each accepted byte gives zero, one or two results packed as one entry.
   sfd_front u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_payload),
      .push  (push),
      .entry (push_entry)
   );

   // Queue: decouples the byte-rate front from the result-rate back.
   sfd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Back: one result per cycle into the output register while rsp_stall does not hold it.
   sfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!q_empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

// ----- verif/tb_stuffed_frame_deframer_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stuffed_frame_deframer_core
// Drives byte transactions into the deframer, works out the payload and status
// transactions each byte should cause, and checks every result against them.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_deframer_core;

   localparam int WATCHDOG_LIMIT = 500;   // cycles with no transaction on either side
   localparam int RANDOM_ITEMS   = 1650;  // counted bytes, ignored ones excluded
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_GAP        = 13;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   sfd_pkg::sfd_req_type req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   sfd_pkg::sfd_rsp_type rsp_payload;

   // expected results, oldest first
   sfd_pkg::sfd_rsp_type pending_results[$];

   // predictor copy of the frame state
   logic        frame_open;
   logic [2:0]  next_slot;
   logic [7:0]  sum_acc;
   logic [7:0]  hdr_opcode;
   logic [7:0]  hdr_type;
   logic [7:0]  hdr_length;
   logic        slash_waiting;

   bit          req_idle_on   = 1'b1;
   bit          rsp_idle_on   = 1'b1;
   int          counted_bytes = 0;
   int          fail_count    = 0;
   int          idle_cycles   = 0;

   stuffed_frame_deframer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int draw_gap(input bit enabled);
      return enabled ? int'($urandom_range(0, MAX_GAP)) : 0;
   endfunction

   // results carry the header fields held so far in the open frame
   function automatic sfd_pkg::sfd_rsp_type payload_result(input logic [7:0] b);
      sfd_pkg::sfd_rsp_type r;
      r.kind            = sfd_pkg::KIND_DATA;
      r.data_byte       = b;
      r.opcode_field    = hdr_opcode;
      r.type_field      = hdr_type;
      r.declared_length = hdr_length;
      r.status          = sfd_pkg::STATUS_GOOD;
      r.last            = 1'b0;
      return r;
   endfunction

   function automatic sfd_pkg::sfd_rsp_type status_result(input sfd_pkg::sfd_status_type st);
      sfd_pkg::sfd_rsp_type r;
      r = payload_result(8'h00);
      r.kind   = sfd_pkg::KIND_STATUS;
      r.status = st;
      return r;
   endfunction

   // Works out the results of one accepted byte transaction and queues them.
   task automatic deframe_byte(input sfd_pkg::sfd_req_type item);
      sfd_pkg::sfd_rsp_type    outs[2];
      int                      n;
      sfd_pkg::sfd_status_type st;
      n = 0;
      if (item.frame_start) begin
         // a start inside an open frame closes that frame as too short
         if (frame_open) begin
            outs[n] = status_result(sfd_pkg::STATUS_SHORT);
            n++;
         end
         frame_open    = 1'b1;
         next_slot     = sfd_pkg::POS_OPCODE;
         sum_acc       = 8'h00;
         hdr_opcode    = 8'h00;
         hdr_type      = 8'h00;
         hdr_length    = 8'h00;
         slash_waiting = 1'b0;
         // start and end on one byte
         if (item.frame_end) begin
            outs[n] = status_result(sfd_pkg::STATUS_SHORT);
            n++;
            frame_open    = 1'b0;
            next_slot     = sfd_pkg::POS_IDLE;
            slash_waiting = 1'b0;
         end
      end else if (frame_open) begin
         if (item.frame_end) begin
            if (next_slot < sfd_pkg::POS_PAYLOAD)
               st = sfd_pkg::STATUS_SHORT;
            else if (item.rx_byte == ~sum_acc)
               st = sfd_pkg::STATUS_GOOD;
            else
               st = sfd_pkg::STATUS_BADSUM;
            // a held slash is flushed as a plain slash ahead of the status
            if (slash_waiting) begin
               outs[n] = payload_result(sfd_pkg::CHAR_SLASH);
               n++;
            end
            outs[n] = status_result(st);
            n++;
            frame_open    = 1'b0;
            next_slot     = sfd_pkg::POS_IDLE;
            slash_waiting = 1'b0;
         end else begin
            sum_acc = sum_acc + item.rx_byte;
            case (next_slot)
               sfd_pkg::POS_OPCODE: begin
                  hdr_opcode = item.rx_byte;
                  next_slot  = sfd_pkg::POS_TYPE;
               end
               sfd_pkg::POS_TYPE: begin
                  hdr_type  = item.rx_byte;
                  next_slot = sfd_pkg::POS_LENGTH;
               end
               sfd_pkg::POS_LENGTH: begin
                  hdr_length = item.rx_byte;
                  next_slot  = sfd_pkg::POS_PAYLOAD;
               end
               default: begin
                  next_slot = sfd_pkg::POS_PAYLOAD;
                  if (slash_waiting) begin
                     slash_waiting = 1'b0;
                     if (item.rx_byte == sfd_pkg::CHAR_DOLLAR) begin
                        outs[n] = payload_result(sfd_pkg::CHAR_DOLLAR);
                        n++;
                     end else begin
                        outs[n] = payload_result(sfd_pkg::CHAR_SLASH);
                        n++;
                        if (item.rx_byte == sfd_pkg::CHAR_SLASH) begin
                           slash_waiting = 1'b1;
                        end else begin
                           outs[n] = payload_result(item.rx_byte);
                           n++;
                        end
                     end
                  end else if (item.rx_byte == sfd_pkg::CHAR_SLASH) begin
                     slash_waiting = 1'b1;
                  end else begin
                     outs[n] = payload_result(item.rx_byte);
                     n++;
                  end
               end
            endcase
         end
      end
      if (n > 0)
         outs[n-1].last = 1'b1;
      for (int i = 0; i < n; i++)
         pending_results.push_back(outs[i]);
   endtask

   // One byte transaction: optional gap, then hold until accepted.
   // Entered and left on a rising edge.
   task automatic send_byte(input logic [7:0] b, input logic fs, input logic fe);
      sfd_pkg::sfd_req_type item;
      int                   gap;
      gap = draw_gap(req_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.rx_byte     = b;
      item.frame_start = fs;
      item.frame_end   = fe;
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (fs || frame_open)
         counted_bytes++;
      deframe_byte(item);
   endtask

   // Start byte, body (header and payload), then the checksum byte.
   task automatic send_frame(input logic [7:0] body[$], input bit corrupt);
      logic [7:0] sum;
      logic [7:0] check;
      sum = 8'h00;
      send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      foreach (body[i]) begin
         send_byte(body[i], 1'b0, 1'b0);
         sum = sum + body[i];
      end
      check = ~sum;
      if (corrupt)
         check = check ^ 8'($urandom_range(1, 255));
      send_byte(check, 1'b0, 1'b1);
   endtask

   function automatic logic [7:0] stuffing_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         return sfd_pkg::CHAR_SLASH;
      else if (pick < 50)
         return sfd_pkg::CHAR_DOLLAR;
      return 8'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------------
   // Test tasks
   // ---------------------------------------------------------------------

   // bytes with no open frame must vanish
   task automatic test_outside_frame();
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
   endtask

   // end mark on the length position: too short, length not captured
   task automatic test_early_end();
      send_byte(8'h7E, 1'b1, 1'b0);
      send_byte(8'h5A, 1'b0, 1'b0);
      send_byte(8'hA5, 1'b0, 1'b0);
      send_byte(8'h3C, 1'b0, 1'b1);
   endtask

   // slash-dollar, slash-other and slash-slash, with a good checksum
   task automatic test_stuffed_good_frame();
      logic [7:0] body[$];
      body = '{8'hFF, 8'h00, 8'h80,
               sfd_pkg::CHAR_SLASH, sfd_pkg::CHAR_DOLLAR,
               sfd_pkg::CHAR_SLASH, 8'h41,
               sfd_pkg::CHAR_SLASH, sfd_pkg::CHAR_SLASH, sfd_pkg::CHAR_DOLLAR};
      send_frame(body, 1'b0);
   endtask

   // slash still held at the checksum, which is also wrong
   task automatic test_slash_at_checksum();
      logic [7:0] body[$];
      body = '{8'h01, 8'h02, 8'h03, sfd_pkg::CHAR_SLASH};
      send_frame(body, 1'b1);
   endtask

   // a new start inside a frame, then a start that also ends
   task automatic test_restart_in_frame();
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'h77, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b1);
   endtask

   // mostly well-formed frames with stuffed payload, the rest broken or noise
   task automatic test_random_traffic();
      logic [7:0] body[$];
      int         pick;
      int         len;
      int         cut;
      counted_bytes = 0;
      while (counted_bytes < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            req_idle_on = ($urandom_range(0, 2) != 0);
            rsp_idle_on = ($urandom_range(0, 2) != 0);
         end
         body.delete();
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
         for (int i = 0; i < 3; i++)
            body.push_back(8'($urandom_range(0, 255)));
         for (int i = 0; i < len; i++)
            body.push_back(stuffing_byte());
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            send_frame(body, $urandom_range(0, 4) == 0);
         end else if (pick < 88) begin
            // truncated frame: end early, or leave it open for the next start
            cut = $urandom_range(0, body.size());
            send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            for (int i = 0; i < cut; i++)
               send_byte(body[i], 1'b0, 1'b0);
            if ($urandom_range(0, 1))
               send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         end else if (pick < 92) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
         end else begin
            // raw noise, start and end marks at random
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                         $urandom_range(0, 3) == 0);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall drawn per transaction, then wait for acceptance
   // ---------------------------------------------------------------------
   initial begin
      int stall_cycles;
      while (reset) @(posedge clock);
      forever begin
         stall_cycles = draw_gap(rsp_idle_on);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      sfd_pkg::sfd_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: result with none expected, expected nothing, actual %p",
                     $time, rsp_payload);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("kind",            want.kind,            rsp_payload.kind);
            compare_field("data_byte",       want.data_byte,       rsp_payload.data_byte);
            compare_field("opcode_field",    want.opcode_field,    rsp_payload.opcode_field);
            compare_field("type_field",      want.type_field,      rsp_payload.type_field);
            compare_field("declared_length", want.declared_length,
                          rsp_payload.declared_length);
            compare_field("status",          want.status,          rsp_payload.status);
            compare_field("last",            want.last,            rsp_payload.last);
         end
      end
   end

   // watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
         $display("** stuffed_frame_deframer_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      frame_open    = 1'b0;
      next_slot     = sfd_pkg::POS_IDLE;
      sum_acc       = 8'h00;
      hdr_opcode    = 8'h00;
      hdr_type      = 8'h00;
      hdr_length    = 8'h00;
      slash_waiting = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_outside_frame();
      test_early_end();
      test_stuffed_good_frame();
      test_slash_at_checksum();
      test_restart_in_frame();
      test_random_traffic();

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** stuffed_frame_deframer_core: PASSED **");
      end else begin
         $display("** stuffed_frame_deframer_core: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/sfd_pkg.sv
src/sfd_front.sv
src/sfd_queue.sv
src/sfd_back.sv
src/stuffed_frame_deframer_core.sv
verif/tb_stuffed_frame_deframer_core.sv
